// ===== hw/rtl/tjd_pkg.sv =====
package tjd_pkg;

    localparam logic [63:0] GOLDEN    = 64'h9e3779b97f4a7c15;
    localparam logic [63:0] MIX_MUL_A = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] MIX_MUL_B = 64'h94d049bb133111eb;
    localparam logic [63:0] SEED_SALT = 64'h243f6a8885a308d3;

    localparam int NUM_FOLDS  = 9;
    localparam int INDEX_LAT  = 5;
    localparam int MIX_LAT    = NUM_FOLDS + 5;
    localparam int DIV_STAGES = 64;
    // sum of the index, mix and divider pipeline depths, from accepted request to result strobe
    localparam int TOTAL_LAT  = INDEX_LAT + MIX_LAT + DIV_STAGES;

    typedef enum logic [2:0] {
        REG_BLOCK_DIM_X  = 3'd0,
        REG_BLOCK_DIM_Y  = 3'd1,
        REG_BLOCK_DIM_Z  = 3'd2,
        REG_GRID_DIM_X   = 3'd3,
        REG_GRID_DIM_Y   = 3'd4,
        REG_GRID_DIM_Z   = 3'd5,
        REG_MAX_DELAY_NS = 3'd6,
        REG_SITE_ID      = 3'd7
    } cfg_idx_t;

    // per-thread values that ride along until folded into the seed
    typedef struct packed {
        logic [4:0]  lane_index;
        logic [5:0]  warp_index;
        logic [7:0]  core_index;
        logic [63:0] launch_id;
        logic [63:0] cycle_count;
        logic [63:0] global_time;
    } tjd_tail_t;

    function automatic logic [63:0] fold_in(input logic [63:0] seed, input logic [63:0] v);
        logic [63:0] t;
        t = v + GOLDEN + (seed << 6) + (seed >> 2);
        return seed ^ t;
    endfunction

endpackage

// ===== hw/rtl/tjd_index.sv =====
module tjd_index
    import tjd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [10:0]       block_dim_x,
    input  logic [10:0]       block_dim_y,
    input  logic [6:0]        block_dim_z,
    input  logic [30:0]       grid_dim_x,
    input  logic [15:0]       grid_dim_y,
    input  logic [15:0]       grid_dim_z,
    input  logic              in_valid,
    input  logic [9:0]        thread_x,
    input  logic [9:0]        thread_y,
    input  logic [5:0]        thread_z,
    input  logic [30:0]       block_x,
    input  logic [15:0]       block_y,
    input  logic [15:0]       block_z,
    input  tjd_tail_t         in_tail,
    output logic              out_valid,
    output logic [63:0]       global_idx,
    output logic [28:0]       tpb,
    output logic [62:0]       big,
    output tjd_tail_t         out_tail
);

    logic        v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    tjd_tail_t   t1_reg, t2_reg, t3_reg, t4_reg, t5_reg;

    // stage 1
    logic [9:0]  tx1_reg, ty1_reg;
    logic [30:0] bx1_reg;
    logic [15:0] by1_reg;
    logic [16:0] a1_reg;
    logic [31:0] b1_reg;
    logic [21:0] p1_reg;
    logic [46:0] q1_reg;
    // stage 2
    logic [9:0]  tx2_reg;
    logic [30:0] bx2_reg;
    logic [28:0] m1_reg;
    logic [63:0] m2_reg;
    logic [28:0] tpb2_reg;
    logic [62:0] big2_reg;
    // stage 3
    logic [29:0] loc3_reg;
    logic [63:0] lin3_reg;
    logic [28:0] tpb3_reg;
    logic [62:0] big3_reg;
    // stage 4
    logic [29:0] loc4_reg;
    logic [60:0] plo4_reg;
    logic [31:0] phi4_reg;
    logic [28:0] tpb4_reg;
    logic [62:0] big4_reg;
    // stage 5
    logic [63:0] glob5_reg;
    logic [28:0] tpb5_reg;
    logic [62:0] big5_reg;

    logic [17:0] ysum;
    logic [32:0] bsum;
    logic [60:0] phi_full;

    assign ysum     = {8'b0, ty1_reg} + {1'b0, a1_reg};
    assign bsum     = {17'b0, by1_reg} + {1'b0, b1_reg};
    assign phi_full = 61'(tpb3_reg) * 61'(lin3_reg[63:32]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        t1_reg   <= in_tail;
        tx1_reg  <= thread_x;
        ty1_reg  <= thread_y;
        bx1_reg  <= block_x;
        by1_reg  <= block_y;
        a1_reg   <= 17'(block_dim_y) * 17'(thread_z);
        b1_reg   <= 32'(grid_dim_y) * 32'(block_z);
        p1_reg   <= 22'(block_dim_x) * 22'(block_dim_y);
        q1_reg   <= 47'(grid_dim_x) * 47'(grid_dim_y);

        t2_reg   <= t1_reg;
        tx2_reg  <= tx1_reg;
        bx2_reg  <= bx1_reg;
        m1_reg   <= 29'(block_dim_x) * 29'(ysum);
        m2_reg   <= 64'(grid_dim_x) * 64'(bsum);
        tpb2_reg <= 29'(p1_reg) * 29'(block_dim_z);
        big2_reg <= 63'(q1_reg) * 63'(grid_dim_z);

        t3_reg   <= t2_reg;
        loc3_reg <= 30'(tx2_reg) + 30'(m1_reg);
        lin3_reg <= 64'(bx2_reg) + m2_reg;
        tpb3_reg <= tpb2_reg;
        big3_reg <= big2_reg;

        t4_reg   <= t3_reg;
        loc4_reg <= loc3_reg;
        plo4_reg <= 61'(tpb3_reg) * 61'(lin3_reg[31:0]);
        phi4_reg <= phi_full[31:0];
        tpb4_reg <= tpb3_reg;
        big4_reg <= big3_reg;

        t5_reg    <= t4_reg;
        glob5_reg <= 64'(loc4_reg) + 64'(plo4_reg) + {phi4_reg, 32'b0};
        tpb5_reg  <= tpb4_reg;
        big5_reg  <= big4_reg;
    end

    assign out_valid  = v5_reg;
    assign global_idx = glob5_reg;
    assign tpb        = tpb5_reg;
    assign big        = big5_reg;
    assign out_tail   = t5_reg;

endmodule

// ===== hw/rtl/tjd_mix.sv =====
module tjd_mix
    import tjd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [63:0] site_id,
    input  logic        in_valid,
    input  logic [63:0] global_idx,
    input  logic [28:0] tpb,
    input  logic [62:0] big,
    input  tjd_tail_t   in_tail,
    output logic        out_valid,
    output logic [63:0] hash
);

    logic [63:0] vals [NUM_FOLDS];
    logic [63:0] vq_reg [NUM_FOLDS][NUM_FOLDS];
    logic [63:0] seed_reg [NUM_FOLDS];
    logic        fv_reg [NUM_FOLDS];

    logic        a1v_reg, a2v_reg, a3v_reg, a4v_reg, a5v_reg;
    logic [63:0] x1_reg, x3_reg, h5_reg;
    logic [63:0] p0a_reg, p0b_reg;
    logic [31:0] p1a_reg, p2a_reg, p1b_reg, p2b_reg;
    logic [63:0] ya, yb;

    assign vals[0] = global_idx;
    assign vals[1] = 64'(tpb);
    assign vals[2] = 64'(big);
    assign vals[3] = 64'(in_tail.lane_index);
    assign vals[4] = 64'(in_tail.warp_index);
    assign vals[5] = 64'(in_tail.core_index);
    assign vals[6] = in_tail.launch_id;
    assign vals[7] = in_tail.cycle_count;
    assign vals[8] = in_tail.global_time;

    // one fold per stage
    for (genvar k = 0; k < NUM_FOLDS; k++)
    begin : g_fold
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                fv_reg[k] <= 1'b0;
            else if (k == 0)
                fv_reg[k] <= in_valid;
            else
                fv_reg[k] <= fv_reg[k-1];
        end

        if (k == 0)
        begin : g_first
            always_ff @(posedge clk)
            begin
                seed_reg[k] <= fold_in(site_id ^ SEED_SALT, vals[0]);
                vq_reg[k]   <= vals;
            end
        end
        else
        begin : g_rest
            always_ff @(posedge clk)
            begin
                seed_reg[k] <= fold_in(seed_reg[k-1], vq_reg[k-1][k]);
                vq_reg[k]   <= vq_reg[k-1];
            end
        end
    end

    // finalizer: low 64 bits of each product from three 32x32 partials
    assign ya = p0a_reg + {p1a_reg + p2a_reg, 32'b0};
    assign yb = p0b_reg + {p1b_reg + p2b_reg, 32'b0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a1v_reg <= 1'b0;
            a2v_reg <= 1'b0;
            a3v_reg <= 1'b0;
            a4v_reg <= 1'b0;
            a5v_reg <= 1'b0;
        end
        else
        begin
            a1v_reg <= fv_reg[NUM_FOLDS-1];
            a2v_reg <= a1v_reg;
            a3v_reg <= a2v_reg;
            a4v_reg <= a3v_reg;
            a5v_reg <= a4v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        x1_reg  <= seed_reg[NUM_FOLDS-1] ^ (seed_reg[NUM_FOLDS-1] >> 30);
        p0a_reg <= 64'(x1_reg[31:0]) * 64'(MIX_MUL_A[31:0]);
        p1a_reg <= x1_reg[31:0] * MIX_MUL_A[63:32];
        p2a_reg <= x1_reg[63:32] * MIX_MUL_A[31:0];
        x3_reg  <= ya ^ (ya >> 27);
        p0b_reg <= 64'(x3_reg[31:0]) * 64'(MIX_MUL_B[31:0]);
        p1b_reg <= x3_reg[31:0] * MIX_MUL_B[63:32];
        p2b_reg <= x3_reg[63:32] * MIX_MUL_B[31:0];
        h5_reg  <= yb ^ (yb >> 31);
    end

    assign out_valid = a5v_reg;
    assign hash      = h5_reg;

endmodule

// ===== hw/rtl/tjd_divider.sv =====
module tjd_divider
    import tjd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [32:0] divisor,
    input  logic        in_valid,
    input  logic [63:0] dividend,
    output logic        out_valid,
    output logic [31:0] remainder
);

    // restoring remainder, one dividend bit per stage, MSB first
    logic        v_reg   [DIV_STAGES];
    logic [31:0] rem_reg [DIV_STAGES];
    logic [63:0] num_reg [DIV_STAGES];

    for (genvar i = 0; i < DIV_STAGES; i++)
    begin : g_stage
        logic [31:0] rem_in;
        logic [63:0] num_in;
        logic        v_in;
        logic [32:0] shifted;
        logic [32:0] diff;

        if (i == 0)
        begin : g_head
            assign rem_in = '0;
            assign num_in = dividend;
            assign v_in   = in_valid;
        end
        else
        begin : g_body
            assign rem_in = rem_reg[i-1];
            assign num_in = num_reg[i-1];
            assign v_in   = v_reg[i-1];
        end

        assign shifted = {rem_in, num_in[63]};
        assign diff    = shifted - divisor;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[i] <= 1'b0;
            else
                v_reg[i] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            rem_reg[i] <= (shifted >= divisor) ? diff[31:0] : shifted[31:0];
            num_reg[i] <= {num_in[62:0], 1'b0};
        end
    end

    assign out_valid = v_reg[DIV_STAGES-1];
    assign remainder = rem_reg[DIV_STAGES-1];

endmodule

// ===== hw/rtl/thread_jitter_delay_hash_unit.sv =====
// Per-thread jitter delay generator. Give a thread's coordinates with start
// high; a request is taken on every cycle (busy always reads low), and once
// it has passed through the whole pipeline, done pulses for one cycle with
// delay_ns valid. Results come out in request order, one per request, and
// cannot be held off: the receiver must take delay_ns in the cycle done is
// high. A request passes through the index arithmetic, the seed folds, the
// finalizer multiplies and the bit-per-stage remainder pipeline, in order.
// Configuration registers are written over the cfg port (always ready) and
// may only change while no request is in flight.
module thread_jitter_delay_hash_unit
    import tjd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [9:0]  thread_x,
    input  logic [9:0]  thread_y,
    input  logic [5:0]  thread_z,
    input  logic [30:0] block_x,
    input  logic [15:0] block_y,
    input  logic [15:0] block_z,
    input  logic [4:0]  lane_index,
    input  logic [5:0]  warp_index,
    input  logic [7:0]  core_index,
    input  logic [63:0] launch_id,
    input  logic [63:0] cycle_count,
    input  logic [63:0] global_time,
    output logic        done,
    output logic [31:0] delay_ns,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    // configuration registers
    logic [10:0] block_dim_x_reg;
    logic [10:0] block_dim_y_reg;
    logic [6:0]  block_dim_z_reg;
    logic [30:0] grid_dim_x_reg;
    logic [15:0] grid_dim_y_reg;
    logic [15:0] grid_dim_z_reg;
    logic [31:0] max_delay_ns_reg;
    logic [63:0] site_id_reg;

    logic        accept;
    tjd_tail_t   in_tail;
    tjd_tail_t   idx_tail;
    logic        idx_valid;
    logic [63:0] idx_global;
    logic [28:0] idx_tpb;
    logic [62:0] idx_big;
    logic        mix_valid;
    logic [63:0] mix_hash;
    logic [32:0] modulus;

    // pipeline never stalls
    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_dim_x_reg  <= 11'd1;
            block_dim_y_reg  <= 11'd1;
            block_dim_z_reg  <= 7'd1;
            grid_dim_x_reg   <= 31'd1;
            grid_dim_y_reg   <= 16'd1;
            grid_dim_z_reg   <= 16'd1;
            max_delay_ns_reg <= 32'd0;
            site_id_reg      <= 64'd0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_idx_t'(cfg_index))
                REG_BLOCK_DIM_X:  block_dim_x_reg  <= cfg_data[10:0];
                REG_BLOCK_DIM_Y:  block_dim_y_reg  <= cfg_data[10:0];
                REG_BLOCK_DIM_Z:  block_dim_z_reg  <= cfg_data[6:0];
                REG_GRID_DIM_X:   grid_dim_x_reg   <= cfg_data[30:0];
                REG_GRID_DIM_Y:   grid_dim_y_reg   <= cfg_data[15:0];
                REG_GRID_DIM_Z:   grid_dim_z_reg   <= cfg_data[15:0];
                REG_MAX_DELAY_NS: max_delay_ns_reg <= cfg_data[31:0];
                REG_SITE_ID:      site_id_reg      <= cfg_data;
                default:          ;
            endcase
        end
    end

    assign in_tail.lane_index  = lane_index;
    assign in_tail.warp_index  = warp_index;
    assign in_tail.core_index  = core_index;
    assign in_tail.launch_id   = launch_id;
    assign in_tail.cycle_count = cycle_count;
    assign in_tail.global_time = global_time;

    // linear thread index, threads per block, blocks per grid
    tjd_index u_index (
        .clk         (clk),
        .rst_n       (rst_n),
        .block_dim_x (block_dim_x_reg),
        .block_dim_y (block_dim_y_reg),
        .block_dim_z (block_dim_z_reg),
        .grid_dim_x  (grid_dim_x_reg),
        .grid_dim_y  (grid_dim_y_reg),
        .grid_dim_z  (grid_dim_z_reg),
        .in_valid    (accept),
        .thread_x    (thread_x),
        .thread_y    (thread_y),
        .thread_z    (thread_z),
        .block_x     (block_x),
        .block_y     (block_y),
        .block_z     (block_z),
        .in_tail     (in_tail),
        .out_valid   (idx_valid),
        .global_idx  (idx_global),
        .tpb         (idx_tpb),
        .big         (idx_big),
        .out_tail    (idx_tail)
    );

    // seed folding and finalizer
    tjd_mix u_mix (
        .clk        (clk),
        .rst_n      (rst_n),
        .site_id    (site_id_reg),
        .in_valid   (idx_valid),
        .global_idx (idx_global),
        .tpb        (idx_tpb),
        .big        (idx_big),
        .in_tail    (idx_tail),
        .out_valid  (mix_valid),
        .hash       (mix_hash)
    );

    // max of zero gives modulus one, so delay zero
    assign modulus = {1'b0, max_delay_ns_reg} + 33'd1;

    tjd_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .divisor   (modulus),
        .in_valid  (mix_valid),
        .dividend  (mix_hash),
        .out_valid (done),
        .remainder (delay_ns)
    );

endmodule

// ===== hw/rtl/tjd_checker.sv =====
module tjd_props
    import tjd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic        done,
    input  logic [31:0] delay_ns,
    input  logic        cfg_valid,
    input  logic        cfg_ready
);

    a_req_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##TOTAL_LAT done)
        else $error("request produced no result");

    a_result_has_req: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy && rst_n, TOTAL_LAT))
        else $error("result without request");

    a_result_known: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !$isunknown(delay_ns))
        else $error("unknown delay on result");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("config write refused");

endmodule

bind thread_jitter_delay_hash_unit tjd_props u_tjd_props (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .done      (done),
    .delay_ns  (delay_ns),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready)
);

// ===== tb/tjd_checker.sv =====
`timescale 1ns / 1ps

module tjd_checker
    import tjd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [9:0]  thread_x,
    input  logic [9:0]  thread_y,
    input  logic [5:0]  thread_z,
    input  logic [30:0] block_x,
    input  logic [15:0] block_y,
    input  logic [15:0] block_z,
    input  logic [4:0]  lane_index,
    input  logic [5:0]  warp_index,
    input  logic [7:0]  core_index,
    input  logic [63:0] launch_id,
    input  logic [63:0] cycle_count,
    input  logic [63:0] global_time,
    input  logic        done,
    input  logic [31:0] delay_ns,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,
    output int          fail_count,
    output int          pending,
    output int          results_seen
);

    // shadow copy of the register file
    logic [10:0] bdx, bdy;
    logic [6:0]  bdz;
    logic [30:0] gdx;
    logic [15:0] gdy, gdz;
    logic [31:0] max_delay;
    logic [63:0] site;

    logic [31:0] delay_q[$];

    function automatic logic [63:0] mix_step(input logic [63:0] s, input logic [63:0] v);
        logic [63:0] t;
        t = v + 64'h9e3779b97f4a7c15 + (s << 6) + (s >> 2);
        return s ^ t;
    endfunction

    function automatic logic [31:0] jitter_delay();
        logic [63:0] loc, lin, tpb, big, gid, s, m;
        loc = 64'(thread_x) + 64'(bdx) * (64'(thread_y) + 64'(bdy) * 64'(thread_z));
        lin = 64'(block_x) + 64'(gdx) * (64'(block_y) + 64'(gdy) * 64'(block_z));
        tpb = 64'(bdx) * 64'(bdy) * 64'(bdz);
        big = 64'(gdx) * 64'(gdy) * 64'(gdz);
        gid = loc + tpb * lin;
        s = site ^ 64'h243f6a8885a308d3;
        s = mix_step(s, gid);
        s = mix_step(s, tpb);
        s = mix_step(s, big);
        s = mix_step(s, 64'(lane_index));
        s = mix_step(s, 64'(warp_index));
        s = mix_step(s, 64'(core_index));
        s = mix_step(s, launch_id);
        s = mix_step(s, cycle_count);
        s = mix_step(s, global_time);
        s = s ^ (s >> 30);
        s = s * 64'hbf58476d1ce4e5b9;
        s = s ^ (s >> 27);
        s = s * 64'h94d049bb133111eb;
        s = s ^ (s >> 31);
        m = 64'(max_delay) + 64'd1;
        return 32'(s % m);
    endfunction

    assign pending = delay_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bdx <= 11'd1; bdy <= 11'd1; bdz <= 7'd1;
            gdx <= 31'd1; gdy <= 16'd1; gdz <= 16'd1;
            max_delay <= '0; site <= '0;
            fail_count <= 0;
            results_seen <= 0;
            delay_q.delete();
        end
        else
        begin
            if (done)
            begin
                results_seen <= results_seen + 1;
                if (delay_q.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("ERROR: unexpected result delay_ns=%0d", delay_ns);
                    fail_count <= fail_count + 1;
                end
                else if (delay_q[0] !== delay_ns)
                begin
                    if (fail_count < 10)
                        $display("ERROR: delay_ns expected %0d got %0d",
                                 delay_q[0], delay_ns);
                    fail_count <= fail_count + 1;
                    void'(delay_q.pop_front());
                end
                else
                    void'(delay_q.pop_front());
            end
            if (start && !busy)
                delay_q.push_back(jitter_delay());
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_idx_t'(cfg_index))
                    REG_BLOCK_DIM_X:  bdx <= cfg_data[10:0];
                    REG_BLOCK_DIM_Y:  bdy <= cfg_data[10:0];
                    REG_BLOCK_DIM_Z:  bdz <= cfg_data[6:0];
                    REG_GRID_DIM_X:   gdx <= cfg_data[30:0];
                    REG_GRID_DIM_Y:   gdy <= cfg_data[15:0];
                    REG_GRID_DIM_Z:   gdz <= cfg_data[15:0];
                    REG_MAX_DELAY_NS: max_delay <= cfg_data[31:0];
                    REG_SITE_ID:      site <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import tjd_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [9:0]  thread_x, thread_y;
    logic [5:0]  thread_z;
    logic [30:0] block_x;
    logic [15:0] block_y, block_z;
    logic [4:0]  lane_index;
    logic [5:0]  warp_index;
    logic [7:0]  core_index;
    logic [63:0] launch_id, cycle_count, global_time;
    logic        done;
    logic [31:0] delay_ns;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [63:0] cfg_data;

    int fail_count, pending, results_seen;
    int sent;
    int idle_pct;     // chance in a hundred that the sender holds off a cycle

    thread_jitter_delay_hash_unit dut (.*);

    tjd_checker chk (.*);

    // 8 ns clock
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // one register write over the cfg channel, held until ready, then cfg_valid is dropped
    task automatic write_reg(input cfg_idx_t idx, input logic [63:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    // drain the pipe: wait out every outstanding request, then the full latency
    task automatic settle();
        int guard;
        guard = 0;
        while (pending != 0 && guard < 100000)
        begin
            @(negedge clk);
            guard++;
        end
        repeat (TOTAL_LAT + 4) @(negedge clk);
    endtask

    // sends one request; start stays high across back-to-back requests
    task automatic send_request(input logic [9:0] tx, input logic [9:0] ty,
                                input logic [5:0] tz, input logic [30:0] bx,
                                input logic [15:0] by, input logic [15:0] bz,
                                input logic [4:0] ln, input logic [5:0] wp,
                                input logic [7:0] cr, input logic [63:0] lid,
                                input logic [63:0] cyc, input logic [63:0] gt);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start <= 1'b1;
        thread_x <= tx; thread_y <= ty; thread_z <= tz;
        block_x <= bx; block_y <= by; block_z <= bz;
        lane_index <= ln; warp_index <= wp; core_index <= cr;
        launch_id <= lid; cycle_count <= cyc; global_time <= gt;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sent++;
        @(negedge clk);
    endtask

    task automatic random_request();
        send_request(10'($urandom), 10'($urandom), 6'($urandom), 31'($urandom),
                     16'($urandom), 16'($urandom), 5'($urandom), 6'($urandom),
                     8'($urandom), {$urandom, $urandom}, {$urandom, $urandom},
                     {$urandom, $urandom});
    endtask

    // random register setting; extremes come up often
    task automatic random_config();
        write_reg(REG_BLOCK_DIM_X, $urandom_range(3) == 0 ? 64'd1024 : 64'($urandom));
        write_reg(REG_BLOCK_DIM_Y, $urandom_range(3) == 0 ? 64'd1 : 64'($urandom));
        write_reg(REG_BLOCK_DIM_Z, 64'($urandom_range(64, 0)));
        write_reg(REG_GRID_DIM_X, $urandom_range(3) == 0 ? 64'h7fffffff : 64'($urandom));
        write_reg(REG_GRID_DIM_Y, 64'($urandom));
        write_reg(REG_GRID_DIM_Z, $urandom_range(3) == 0 ? 64'hffff : 64'($urandom));
        case ($urandom_range(3))
            0: write_reg(REG_MAX_DELAY_NS, 64'd0);
            1: write_reg(REG_MAX_DELAY_NS, 64'hffffffff);
            2: write_reg(REG_MAX_DELAY_NS, 64'($urandom_range(1000)));
            default: write_reg(REG_MAX_DELAY_NS, 64'($urandom));
        endcase
        write_reg(REG_SITE_ID, {$urandom, $urandom});
    endtask

    initial
    begin
        #20ms;
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        {thread_x, thread_y, thread_z, block_x, block_y, block_z} = '0;
        {lane_index, warp_index, core_index} = '0;
        {launch_id, cycle_count, global_time} = '0;
        sent = 0;
        idle_pct = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset values: max delay zero forces delay zero
        send_request('0, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0);
        send_request('1, '1, '1, '1, '1, '1, '1, '1, '1, '1, '1, '1);
        start <= 1'b0;
        settle();

        // full-scale dimensions, widest modulus
        write_reg(REG_BLOCK_DIM_X, 64'd1024);
        write_reg(REG_BLOCK_DIM_Y, 64'd1024);
        write_reg(REG_BLOCK_DIM_Z, 64'd64);
        write_reg(REG_GRID_DIM_X, 64'h7fffffff);
        write_reg(REG_GRID_DIM_Y, 64'hffff);
        write_reg(REG_GRID_DIM_Z, 64'hffff);
        write_reg(REG_MAX_DELAY_NS, 64'hffffffff);
        write_reg(REG_SITE_ID, '1);
        send_request('0, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0);
        send_request('1, '1, '1, '1, '1, '1, '1, '1, '1, '1, '1, '1);
        // block x and z coordinates past their dimension
        send_request(10'd1023, 10'd0, 6'd63, 31'h7fffffff, 16'd0, 16'hffff,
                     5'd31, 6'd0, 8'd255, 64'h8000000000000000, '0, 64'd1);
        send_request(10'h2aa, 10'h155, 6'h2a, 31'h2aaaaaaa, 16'h5555, 16'haaaa,
                     5'h15, 6'h2a, 8'h55, {32{2'b10}}, {32{2'b01}}, {32{2'b10}});
        start <= 1'b0;
        settle();

        // zero and oversized dimensions, modulus of two
        write_reg(REG_BLOCK_DIM_X, 64'd0);
        write_reg(REG_BLOCK_DIM_Y, 64'h7ff);
        write_reg(REG_BLOCK_DIM_Z, 64'h7f);
        write_reg(REG_GRID_DIM_X, 64'd0);
        write_reg(REG_MAX_DELAY_NS, 64'd1);
        write_reg(REG_SITE_ID, '0);
        repeat (6) random_request();
        start <= 1'b0;
        settle();

        // random phases: sender idles 6 in 100, then 84 in 100, then never
        for (int ph = 0; ph < 12; ph++)
        begin
            idle_pct = (ph < 4) ? 6 : (ph < 8) ? 84 : 0;
            random_config();
            for (int n = 0; n < 125; n++)
            begin
                random_request();
                // sender holds off until every result is back
                if (n == 60 && ph == 2)
                begin
                    start <= 1'b0;
                    while (pending != 0)
                        @(negedge clk);
                end
            end
            start <= 1'b0;
            settle();
        end

        $display("Sent %0d requests, checked %0d results over 12 random register settings",
                 sent, results_seen);
        $display("plus directed extremes: reset values, full-scale and zero dimensions.");
        if (fail_count == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
